// File: design/mctp_sfr_pkg.sv
package mctp_sfr_pkg;

   localparam logic [7:0] SYNC_BYTE   = 8'h7E;
   localparam logic [7:0] ESC_BYTE    = 8'h7D;
   localparam logic [7:0] ESC_SYNC    = 8'h5E;
   localparam logic [7:0] ESC_ESC     = 8'h5D;
   localparam logic [7:0] ESC_OFFSET  = 8'h20;
   localparam logic [7:0] SERIAL_REV  = 8'h01;
   localparam logic [7:0] HDR_VERSION = 8'h01;
   localparam logic [7:0] MIN_COUNT   = 8'h04;
   localparam logic [7:0] HDR_BYTES   = 8'h05;
   localparam logic [15:0] CHECK_INIT = 16'hFFFF;
   localparam logic [15:0] CHECK_POLY = 16'h8408;

   localparam logic [7:0] RST_DEST_ID   = 8'h00;
   localparam logic [7:0] RST_SRC_ID    = 8'h00;
   localparam logic [7:0] RST_FLAGS     = 8'hC8;
   localparam logic [7:0] RST_DISCOVERY = 8'h0D;

   localparam logic [1:0] REG_DEST_ID   = 2'd0;
   localparam logic [1:0] REG_SRC_ID    = 2'd1;
   localparam logic [1:0] REG_FLAGS     = 2'd2;
   localparam logic [1:0] REG_DISCOVERY = 2'd3;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_DATA    = 3'd1;
   localparam logic [2:0] EV_CTRL    = 3'd2;
   localparam logic [2:0] EV_FAIL    = 3'd3;
   localparam logic [2:0] EV_ABANDON = 3'd4;

   typedef struct packed {
      logic [7:0] dest_id;
      logic [7:0] src_id;
      logic [7:0] flags;
      logic [7:0] discovery_cmd;
   } cfg_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [2:0] frame_event;
      logic       message_type;
      logic       discovered;
   } rsp_type;

   // Reflected CRC-16, one byte folded in per call.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CHECK_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: design/mctp_sfr_csr.sv
module mctp_sfr_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output mctp_sfr_pkg::cfg_type cfg
);

   mctp_sfr_pkg::cfg_type cfg_ff;
   mctp_sfr_pkg::cfg_type cfg_in;
   logic                  wr_en;
   logic [1:0]            reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            mctp_sfr_pkg::REG_DEST_ID:   cfg_in.dest_id       = pwdata[7:0];
            mctp_sfr_pkg::REG_SRC_ID:    cfg_in.src_id        = pwdata[7:0];
            mctp_sfr_pkg::REG_FLAGS:     cfg_in.flags         = pwdata[7:0];
            mctp_sfr_pkg::REG_DISCOVERY: cfg_in.discovery_cmd = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_id       <= mctp_sfr_pkg::RST_DEST_ID;
         cfg_ff.src_id        <= mctp_sfr_pkg::RST_SRC_ID;
         cfg_ff.flags         <= mctp_sfr_pkg::RST_FLAGS;
         cfg_ff.discovery_cmd <= mctp_sfr_pkg::RST_DISCOVERY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         mctp_sfr_pkg::REG_DEST_ID:   prdata = {24'h000000, cfg_ff.dest_id};
         mctp_sfr_pkg::REG_SRC_ID:    prdata = {24'h000000, cfg_ff.src_id};
         mctp_sfr_pkg::REG_FLAGS:     prdata = {24'h000000, cfg_ff.flags};
         mctp_sfr_pkg::REG_DISCOVERY: prdata = {24'h000000, cfg_ff.discovery_cmd};
         default:                     prdata = 32'h00000000;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: design/mctp_sfr_deframer.sv
module mctp_sfr_deframer (
   input  logic                  clock,
   input  logic                  reset,
   input  mctp_sfr_pkg::cfg_type cfg,
   input  logic                  take,
   input  logic [7:0]            in_byte,
   input  logic                  out_stall,
   output logic                  out_valid,
   output mctp_sfr_pkg::rsp_type out_rsp
);

   typedef enum logic [3:0] {
      PH_HUNT, PH_REV, PH_COUNT, PH_VER, PH_DEST, PH_SRC, PH_FLAGS, PH_TYPE,
      PH_BODY, PH_ESC, PH_CHK_HI, PH_CHK_LO, PH_END
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] running_ff, running_in;
   logic [15:0] received_ff, received_in;
   logic [7:0]  count_ff, count_in;
   logic        msg_type_ff, msg_type_in;
   logic [7:0]  command_ff, command_in;
   logic        discovered_ff, discovered_in;
   logic        out_valid_ff, out_valid_in;
   logic        pvalid_ff, pvalid_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [7:0]  pindex_ff, pindex_in;
   logic [2:0]  event_ff, event_in;

   logic [15:0] crc_base;
   logic [7:0]  crc_data;
   logic [15:0] crc_out;
   logic        esc_ok;

   // One shared CRC byte update; a sync seen while hunting restarts from the seed.
   always_comb begin
      crc_base = ((phase_ff == PH_HUNT) ||
                  ((phase_ff == PH_REV) && (in_byte == mctp_sfr_pkg::SYNC_BYTE))) ?
                 mctp_sfr_pkg::CHECK_INIT : running_ff;
      crc_data = (phase_ff == PH_ESC) ? in_byte + mctp_sfr_pkg::ESC_OFFSET : in_byte;
      crc_out  = mctp_sfr_pkg::crc_byte(crc_base, crc_data);
      esc_ok   = (in_byte == mctp_sfr_pkg::ESC_SYNC) || (in_byte == mctp_sfr_pkg::ESC_ESC);
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      running_in    = running_ff;
      received_in   = received_ff;
      count_in      = count_ff;
      msg_type_in   = msg_type_ff;
      command_in    = command_ff;
      discovered_in = discovered_ff;
      pvalid_in     = 1'b0;
      pbyte_in      = 8'h00;
      pindex_in     = 8'h00;
      event_in      = mctp_sfr_pkg::EV_NONE;

      case (phase_ff)
         PH_HUNT: begin
            if (in_byte == mctp_sfr_pkg::SYNC_BYTE) begin
               running_in = crc_out;
               phase_in   = PH_REV;
            end
         end
         PH_REV: begin
            if (in_byte == mctp_sfr_pkg::SYNC_BYTE) begin
               running_in = crc_out;
            end else if (in_byte == mctp_sfr_pkg::SERIAL_REV) begin
               running_in = crc_out;
               phase_in   = PH_COUNT;
            end else begin
               phase_in = PH_HUNT;
               event_in = mctp_sfr_pkg::EV_ABANDON;
            end
         end
         PH_COUNT: begin
            if (in_byte > mctp_sfr_pkg::MIN_COUNT) begin
               bytes_left_in = in_byte - mctp_sfr_pkg::HDR_BYTES;
               count_in      = 8'h00;
               running_in    = crc_out;
               phase_in      = PH_VER;
            end else begin
               phase_in = PH_HUNT;
               event_in = mctp_sfr_pkg::EV_ABANDON;
            end
         end
         PH_VER, PH_DEST, PH_SRC, PH_FLAGS: begin
            if (((phase_ff == PH_VER)   && (in_byte == mctp_sfr_pkg::HDR_VERSION)) ||
                ((phase_ff == PH_DEST)  && (in_byte == cfg.dest_id)) ||
                ((phase_ff == PH_SRC)   && (in_byte == cfg.src_id)) ||
                ((phase_ff == PH_FLAGS) && (in_byte == cfg.flags))) begin
               running_in = crc_out;
               case (phase_ff)
                  PH_VER:  phase_in = PH_DEST;
                  PH_DEST: phase_in = PH_SRC;
                  PH_SRC:  phase_in = PH_FLAGS;
                  default: phase_in = PH_TYPE;
               endcase
            end else begin
               phase_in = PH_HUNT;
               event_in = mctp_sfr_pkg::EV_ABANDON;
            end
         end
         PH_TYPE: begin
            if (in_byte[7:1] == 7'd0) begin
               msg_type_in = in_byte[0];
               running_in  = crc_out;
               // empty body skips straight to the check bytes
               phase_in    = (bytes_left_ff == 8'h00) ? PH_CHK_HI : PH_BODY;
            end else begin
               phase_in = PH_HUNT;
               event_in = mctp_sfr_pkg::EV_ABANDON;
            end
         end
         PH_BODY, PH_ESC: begin
            if ((phase_ff == PH_BODY) && (in_byte == mctp_sfr_pkg::ESC_BYTE)) begin
               phase_in = PH_ESC;
            end else if (((phase_ff == PH_BODY) && (in_byte == mctp_sfr_pkg::SYNC_BYTE)) ||
                         ((phase_ff == PH_ESC) && !esc_ok)) begin
               phase_in = PH_HUNT;
               event_in = mctp_sfr_pkg::EV_ABANDON;
            end else begin
               pvalid_in = 1'b1;
               pbyte_in  = crc_data;
               pindex_in = count_ff;
               if (count_ff == 8'h01) begin
                  command_in = crc_data;
               end
               count_in      = count_ff + 8'h01;
               running_in    = crc_out;
               bytes_left_in = bytes_left_ff - 8'h01;
               phase_in      = (bytes_left_ff == 8'h01) ? PH_CHK_HI : PH_BODY;
            end
         end
         PH_CHK_HI: begin
            received_in = {in_byte, 8'h00};
            phase_in    = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            received_in = {received_ff[15:8], in_byte};
            phase_in    = PH_END;
         end
         PH_END: begin
            if ((in_byte == mctp_sfr_pkg::SYNC_BYTE) && (running_ff == received_ff)) begin
               if (!msg_type_ff) begin
                  event_in = mctp_sfr_pkg::EV_CTRL;
                  if ((count_ff >= 8'h02) && (command_ff == cfg.discovery_cmd)) begin
                     discovered_in = 1'b1;
                  end
               end else begin
                  event_in = mctp_sfr_pkg::EV_DATA;
               end
            end else begin
               event_in = mctp_sfr_pkg::EV_FAIL;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Hold the result while the receiver stalls; load a new one on take.
   assign out_valid_in = take || (out_valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= 8'h00;
         running_ff    <= 16'h0000;
         received_ff   <= 16'h0000;
         count_ff      <= 8'h00;
         msg_type_ff   <= 1'b0;
         command_ff    <= 8'h00;
         discovered_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            running_ff    <= running_in;
            received_ff   <= received_in;
            count_ff      <= count_in;
            msg_type_ff   <= msg_type_in;
            command_ff    <= command_in;
            discovered_ff <= discovered_in;
         end
      end
      if (take) begin
         pvalid_ff <= pvalid_in;
         pbyte_ff  <= pbyte_in;
         pindex_ff <= pindex_in;
         event_ff  <= event_in;
      end
   end

   assign out_valid             = out_valid_ff;
   assign out_rsp.payload_valid = pvalid_ff;
   assign out_rsp.payload_byte  = pbyte_ff;
   assign out_rsp.payload_index = pindex_ff;
   assign out_rsp.frame_event   = event_ff;
   assign out_rsp.message_type  = msg_type_ff;
   assign out_rsp.discovered    = discovered_ff;

endmodule

// File: design/mctp_serial_frame_receiver_top.sv
// Serial-bound management packet receiver.
// Request channel (req_valid, req_stall, req_rx_byte) carries one received
// serial byte per request. Every request yields exactly one result on the
// rsp_ channel: the unescaped body byte with its index when payload_valid is
// set, a frame event (none, data good, control good, check failed,
// abandoned), the current message type and the sticky discovered flag.
// The byte lands in the input register; the deframer state and the CRC-16
// byte update run between that register and the result register.
// Throughput is one byte per cycle while rsp_stall does not hold the result
// register; the CRC byte update and state transition are combinational.
// When rsp_stall is high the result register holds; one more request can be
// taken into the input register, after which req_stall rises until the
// result is taken.
// Reset (synchronous) returns the deframer to sync hunting, clears the
// discovered flag and loads the register defaults over the APB-style port
// (dest id, src id, flags, discovery command code at 0x0, 0x4, 0x8, 0xC).
module mctp_serial_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [2:0]  rsp_frame_event,
   output logic        rsp_message_type,
   output logic        rsp_discovered,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   mctp_sfr_pkg::cfg_type cfg;
   mctp_sfr_pkg::rsp_type rsp;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       out_free;
   logic       take;
   logic       req_accept;

   mctp_sfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign out_free   = !rsp_valid || !rsp_stall;
   assign take       = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept || (s1_valid_ff && !take);
   assign s1_byte_in  = req_accept ? req_rx_byte : s1_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_byte_ff <= s1_byte_in;
   end

   mctp_sfr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .take      (take),
      .in_byte   (s1_byte_ff),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_rsp   (rsp)
   );

   assign rsp_payload_valid = rsp.payload_valid;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_payload_index = rsp.payload_index;
   assign rsp_frame_event   = rsp.frame_event;
   assign rsp_message_type  = rsp.message_type;
   assign rsp_discovered    = rsp.discovered;

   a_no_event_with_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_valid) |-> (rsp_frame_event == mctp_sfr_pkg::EV_NONE))
      else $error("frame event reported together with a body byte");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with an empty input register");

   a_discovered_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_discovered |=> rsp_discovered)
      else $error("discovered flag cleared outside reset");

endmodule
